### src/mbts_pkg.sv
package mbts_pkg;

    localparam int ADDR_BITS = 30;
    localparam int OFF_W     = 31;

    localparam logic [31:0] PAT_A     = 32'hAAAA_AAAA;
    localparam logic [31:0] PAT_B     = 32'h5555_5555;
    localparam logic [31:0] HASH_MUL  = 32'h045D_9F3B;
    localparam logic [4:0]  SIZE_RST  = 5'd30;
    localparam logic [31:0] SEED_RST  = 32'hDEAD_BEEF;

    localparam logic [0:0] REG_SIZE = 1'b0;
    localparam logic [0:0] REG_SEED = 1'b1;

    localparam logic [1:0] K_WRITE = 2'd0;
    localparam logic [1:0] K_READ  = 2'd1;
    localparam logic [1:0] K_PASS  = 2'd2;
    localparam logic [1:0] K_FAIL  = 2'd3;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_ADDR  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [31:0] read_data;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  command_kind;
        logic [29:0] byte_offset;
        logic [31:0] write_value;
        logic [1:0]  test_stage;
    } t_out_word;

    typedef enum logic [3:0] {
        PH_IDLE, PH_DB_WR, PH_DB_RD, PH_AB_FILL, PH_AB_W0, PH_AB_HI_RD, PH_AB_RST0,
        PH_AB_VW, PH_AB_V0RD, PH_AB_VRD, PH_AB_VRST, PH_SW_WR, PH_SW_RD
    } t_phase;

    typedef enum logic [2:0] {
        C_IDLE, C_WAIT, C_HASH1, C_HASH2, C_OUT
    } t_ctl_state;

    typedef struct packed {
        logic   load;
        logic   hash_go;
        logic   hash_stage2;
        logic   finish;
    } t_cmd;

endpackage

### src/mbts_ctrl.sv
module mbts_ctrl import mbts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  logic      i_need_hash,
    output t_cmd      o_cmd
);
    t_ctl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            C_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = C_WAIT;
                end
            end
            C_WAIT: begin
                if (i_need_hash) begin
                    o_cmd.hash_go = 1'b1;
                    n_state       = C_HASH1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = C_OUT;
                end
            end
            C_HASH1: begin
                o_cmd.hash_stage2 = 1'b1;
                n_state           = C_HASH2;
            end
            C_HASH2: begin
                o_cmd.finish = 1'b1;
                n_state      = C_OUT;
            end
            C_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end
endmodule

### src/mbts_dp.sv
module mbts_dp import mbts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in_word    i_in,
    input  logic [4:0]  i_size_log2,
    input  logic [31:0] i_seed,
    output logic        o_need_hash,
    output t_out_word   o_out
);
    t_phase      r_phase, n_phase;
    logic [31:0] r_walk, n_walk;
    logic [OFF_W-1:0] r_probe, n_probe, r_victim, n_victim;
    logic [31:0] r_sweep, n_sweep, r_exp, n_exp;
    logic [31:0] r_rd;
    logic        r_op;
    t_out_word   r_out, n_out;
    logic [31:0] r_hmul;
    logic [31:0] hsel, hxor;
    logic [OFF_W:0] size;
    logic [4:0]  e;
    logic [OFF_W:0] p2, p4, v2;
    logic        adv, big;
    logic [31:0] hres;

    assign e    = (i_size_log2 > 5'(ADDR_BITS)) ? 5'(ADDR_BITS) : i_size_log2;
    assign size = (OFF_W+1)'(1) << e;
    assign p2   = {r_probe, 1'b0};
    assign p4   = {1'b0, r_probe} + (OFF_W+1)'(4);
    assign v2   = {r_victim, 1'b0};
    assign big  = size > (OFF_W+1)'(4);
    assign adv  = r_op && (r_phase != PH_IDLE);

    // hash needed: sweep begin from address test, sweep write continue/switch, sweep read next
    always_comb begin
        o_need_hash = 1'b0;
        hsel        = i_seed;
        if (adv) begin
            unique case (r_phase)
                PH_AB_RST0: o_need_hash = !big;
                PH_AB_VRST: o_need_hash = !(v2 < size);
                PH_SW_WR: begin
                    o_need_hash = 1'b1;
                    hsel        = (p4 < size) ? r_sweep : i_seed;
                end
                PH_SW_RD: begin
                    o_need_hash = (r_rd == r_exp) && (p4 < size);
                    hsel        = r_exp;
                end
                default: o_need_hash = 1'b0;
            endcase
        end
    end

    assign hxor = (i_cmd.hash_stage2 ? r_hmul : hsel);

    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_go || i_cmd.hash_stage2) begin
            r_hmul <= ((hxor >> 16) ^ hxor) * HASH_MUL;
        end
    end

    assign hres = (r_hmul >> 16) ^ r_hmul;

    function automatic t_out_word mk(logic [1:0] k, logic [OFF_W-1:0] off,
                                     logic [31:0] v, logic [1:0] s);
        t_out_word w;
        w.command_kind = k;
        w.byte_offset  = off[29:0];
        w.write_value  = (k == K_WRITE) ? v : 32'd0;
        w.test_stage   = s;
        return w;
    endfunction

    always_comb begin
        n_phase  = r_phase;
        n_walk   = r_walk;
        n_probe  = r_probe;
        n_victim = r_victim;
        n_sweep  = r_sweep;
        n_exp    = r_exp;
        n_out    = r_out;
        if (!adv) begin
            n_walk   = 32'd1;
            n_probe  = '0;
            n_victim = '0;
            n_phase  = PH_DB_WR;
            n_out    = mk(K_WRITE, '0, 32'd1, ST_DATA);
        end else begin
            unique case (r_phase)
                PH_DB_WR: begin
                    n_phase = PH_DB_RD;
                    n_out   = mk(K_READ, '0, '0, ST_DATA);
                end
                PH_DB_RD: begin
                    if (r_rd != r_walk) begin
                        n_phase = PH_IDLE;
                        n_out   = mk(K_FAIL, '0, '0, ST_DATA);
                    end else begin
                        n_walk = r_walk << 1;
                        if (r_walk[31]) begin
                            if (big) begin
                                n_probe = OFF_W'(4);
                                n_phase = PH_AB_FILL;
                                n_out   = mk(K_WRITE, OFF_W'(4), PAT_A, ST_ADDR);
                            end else begin
                                n_phase = PH_AB_W0;
                                n_out   = mk(K_WRITE, '0, PAT_B, ST_ADDR);
                            end
                        end else begin
                            n_phase = PH_DB_WR;
                            n_out   = mk(K_WRITE, '0, r_walk << 1, ST_DATA);
                        end
                    end
                end
                PH_AB_FILL: begin
                    n_probe = p2[OFF_W-1:0];
                    if (p2 < size) begin
                        n_out = mk(K_WRITE, p2[OFF_W-1:0], PAT_A, ST_ADDR);
                    end else begin
                        n_phase = PH_AB_W0;
                        n_out   = mk(K_WRITE, '0, PAT_B, ST_ADDR);
                    end
                end
                PH_AB_W0: begin
                    if (big) begin
                        n_probe = OFF_W'(4);
                        n_phase = PH_AB_HI_RD;
                        n_out   = mk(K_READ, OFF_W'(4), '0, ST_ADDR);
                    end else begin
                        n_phase = PH_AB_RST0;
                        n_out   = mk(K_WRITE, '0, PAT_A, ST_ADDR);
                    end
                end
                PH_AB_HI_RD: begin
                    if (r_rd != PAT_A) begin
                        n_phase = PH_IDLE;
                        n_out   = mk(K_FAIL, r_probe, '0, ST_ADDR);
                    end else begin
                        n_probe = p2[OFF_W-1:0];
                        if (p2 < size) begin
                            n_out = mk(K_READ, p2[OFF_W-1:0], '0, ST_ADDR);
                        end else begin
                            n_phase = PH_AB_RST0;
                            n_out   = mk(K_WRITE, '0, PAT_A, ST_ADDR);
                        end
                    end
                end
                PH_AB_RST0: begin
                    n_victim = OFF_W'(4);
                    if (big) begin
                        n_phase = PH_AB_VW;
                        n_out   = mk(K_WRITE, OFF_W'(4), PAT_B, ST_ADDR);
                    end else begin
                        n_probe = '0;
                        n_phase = PH_SW_WR;
                        n_out   = mk(K_WRITE, '0, hres, ST_SWEEP);
                        n_sweep = hres;
                    end
                end
                PH_AB_VW: begin
                    n_phase = PH_AB_V0RD;
                    n_out   = mk(K_READ, '0, '0, ST_ADDR);
                end
                PH_AB_V0RD: begin
                    if (r_rd != PAT_A) begin
                        n_phase = PH_IDLE;
                        n_out   = mk(K_FAIL, '0, '0, ST_ADDR);
                    end else begin
                        n_probe = OFF_W'(4);
                        n_phase = PH_AB_VRD;
                        n_out   = mk(K_READ, OFF_W'(4), '0, ST_ADDR);
                    end
                end
                PH_AB_VRD: begin
                    if (r_rd != PAT_A && r_probe != r_victim) begin
                        n_phase = PH_IDLE;
                        n_out   = mk(K_FAIL, r_probe, '0, ST_ADDR);
                    end else begin
                        n_probe = p2[OFF_W-1:0];
                        if (p2 < size) begin
                            n_out = mk(K_READ, p2[OFF_W-1:0], '0, ST_ADDR);
                        end else begin
                            n_phase = PH_AB_VRST;
                            n_out   = mk(K_WRITE, r_victim, PAT_A, ST_ADDR);
                        end
                    end
                end
                PH_AB_VRST: begin
                    n_victim = v2[OFF_W-1:0];
                    if (v2 < size) begin
                        n_phase = PH_AB_VW;
                        n_out   = mk(K_WRITE, v2[OFF_W-1:0], PAT_B, ST_ADDR);
                    end else begin
                        n_probe = '0;
                        n_phase = PH_SW_WR;
                        n_out   = mk(K_WRITE, '0, hres, ST_SWEEP);
                        n_sweep = hres;
                    end
                end
                PH_SW_WR: begin
                    if (p4 < size) begin
                        n_probe = p4[OFF_W-1:0];
                        n_sweep = hres;
                        n_out   = mk(K_WRITE, p4[OFF_W-1:0], hres, ST_SWEEP);
                    end else begin
                        n_probe = '0;
                        n_exp   = hres;
                        n_phase = PH_SW_RD;
                        n_out   = mk(K_READ, '0, '0, ST_SWEEP);
                    end
                end
                PH_SW_RD: begin
                    if (r_rd != r_exp) begin
                        n_phase = PH_IDLE;
                        n_out   = mk(K_FAIL, r_probe, '0, ST_SWEEP);
                    end else begin
                        n_probe = p4[OFF_W-1:0];
                        if (p4 < size) begin
                            n_exp = hres;
                            n_out = mk(K_READ, p4[OFF_W-1:0], '0, ST_SWEEP);
                        end else begin
                            n_phase = PH_IDLE;
                            n_out   = mk(K_PASS, '0, '0, ST_SWEEP);
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_out   = mk(K_FAIL, '0, '0, ST_DATA);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_walk   <= 32'd1;
            r_probe  <= '0;
            r_victim <= '0;
            r_sweep  <= '0;
            r_exp    <= '0;
        end else if (i_cmd.finish) begin
            r_phase  <= n_phase;
            r_walk   <= n_walk;
            r_probe  <= n_probe;
            r_victim <= n_victim;
            r_sweep  <= n_sweep;
            r_exp    <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_in.operation;
            r_rd <= i_in.read_data;
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;
endmodule

### src/memory_bus_test_sequencer_top.sv
// Memory self-test sequencer: a start word runs a walking-ones data bus test,
// an address bus test and a hashed pseudo-random sweep; each advance word
// carries the previous read data and yields one write, read, pass or fail word.
// The accepted word is registered, then the result is registered and offered, after
// the sweep hash (two chained constant multiplies, one per cycle) when it is needed;
// the next input word is taken in the cycle after the result leaves, and only one
// item is in flight at a time; an output stall holds the result and the input.
module memory_bus_test_sequencer_top import mbts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [4:0]  r_size_log2;
    logic [31:0] r_seed;
    t_cmd        cmd;
    logic        need_hash;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= SIZE_RST;
            r_seed      <= SEED_RST;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_SIZE) begin
                r_size_log2 <= pwdata[4:0];
            end else begin
                r_seed <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            prdata = (paddr[2] == REG_SEED) ? r_seed : {27'd0, r_size_log2};
        end
    end

    mbts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_need_hash (need_hash),
        .o_cmd       (cmd)
    );

    mbts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in_data),
        .i_size_log2 (r_size_log2),
        .i_seed      (r_seed),
        .o_need_hash (need_hash),
        .o_out       (o_out_data)
    );
endmodule

### src/mbts_checker.sv
module mbts_checker import mbts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      o_in_ready,
    input  logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_out_word o_out_data
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");

    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready) else $error("second accept");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.command_kind != K_WRITE) |-> o_out_data.write_value == 0)
        else $error("nonzero value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped");
endmodule

bind memory_bus_test_sequencer_top mbts_checker u_mbts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### tb/memory_bus_test_sequencer_top_tb.sv
module memory_bus_test_sequencer_top_tb import mbts_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    class selftest_scoreboard;
        logic [4:0]  size_log2 = SIZE_RST;
        logic [31:0] sweep_seed = SEED_RST;
        t_phase      phase = PH_IDLE;
        logic [31:0] walk = 32'd1;
        logic [63:0] probe = '0;
        logic [63:0] victim = '0;
        logic [31:0] sweep_val = '0;
        logic [31:0] exp_word = '0;
        t_out_word   pending[$];
        t_out_word   last_cmd;
        logic [31:0] mem_image[logic [63:0]];
        int          errors = 0;

        function logic [31:0] hash32(logic [31:0] x);
            x = ((x >> 16) ^ x) * HASH_MUL;
            x = ((x >> 16) ^ x) * HASH_MUL;
            return (x >> 16) ^ x;
        endfunction

        function t_out_word cmd(logic [1:0] kind, logic [63:0] off, logic [31:0] val,
                                logic [1:0] stage);
            t_out_word c;
            c.command_kind = kind;
            c.byte_offset  = off[29:0];
            c.write_value  = (kind == K_WRITE) ? val : 32'd0;
            c.test_stage   = stage;
            return c;
        endfunction

        function t_out_word start_sweep();
            sweep_val = hash32(sweep_seed);
            probe = 0;
            phase = PH_SW_WR;
            return cmd(K_WRITE, 0, sweep_val, ST_SWEEP);
        endfunction

        function t_out_word fail_at(logic [63:0] off, logic [1:0] stage);
            phase = PH_IDLE;
            return cmd(K_FAIL, off, 0, stage);
        endfunction

        function void note_input(t_in_word w);
            logic [63:0] size;
            logic [31:0] rd;
            t_out_word   r;
            size = 64'd1 << ((size_log2 > 5'd30) ? 30 : size_log2);
            rd = w.read_data;
            if (!w.operation || phase == PH_IDLE) begin
                walk = 1; probe = 0; victim = 0; phase = PH_DB_WR;
                r = cmd(K_WRITE, 0, walk, ST_DATA);
            end else begin
                case (phase)
                    PH_DB_WR: begin
                        phase = PH_DB_RD;
                        r = cmd(K_READ, 0, 0, ST_DATA);
                    end
                    PH_DB_RD: begin
                        if (rd != walk) r = fail_at(0, ST_DATA);
                        else begin
                            walk = walk << 1;
                            if (walk == 0) begin
                                if (size > 4) begin
                                    probe = 4; phase = PH_AB_FILL;
                                    r = cmd(K_WRITE, 4, PAT_A, ST_ADDR);
                                end else begin
                                    phase = PH_AB_W0;
                                    r = cmd(K_WRITE, 0, PAT_B, ST_ADDR);
                                end
                            end else begin
                                phase = PH_DB_WR;
                                r = cmd(K_WRITE, 0, walk, ST_DATA);
                            end
                        end
                    end
                    PH_AB_FILL: begin
                        probe = probe << 1;
                        if (probe < size) r = cmd(K_WRITE, probe, PAT_A, ST_ADDR);
                        else begin
                            phase = PH_AB_W0;
                            r = cmd(K_WRITE, 0, PAT_B, ST_ADDR);
                        end
                    end
                    PH_AB_W0: begin
                        if (size > 4) begin
                            probe = 4; phase = PH_AB_HI_RD;
                            r = cmd(K_READ, 4, 0, ST_ADDR);
                        end else begin
                            phase = PH_AB_RST0;
                            r = cmd(K_WRITE, 0, PAT_A, ST_ADDR);
                        end
                    end
                    PH_AB_HI_RD: begin
                        if (rd != PAT_A) r = fail_at(probe, ST_ADDR);
                        else begin
                            probe = probe << 1;
                            if (probe < size) r = cmd(K_READ, probe, 0, ST_ADDR);
                            else begin
                                phase = PH_AB_RST0;
                                r = cmd(K_WRITE, 0, PAT_A, ST_ADDR);
                            end
                        end
                    end
                    PH_AB_RST0: begin
                        victim = 4;
                        if (victim < size) begin
                            phase = PH_AB_VW;
                            r = cmd(K_WRITE, victim, PAT_B, ST_ADDR);
                        end else r = start_sweep();
                    end
                    PH_AB_VW: begin
                        phase = PH_AB_V0RD;
                        r = cmd(K_READ, 0, 0, ST_ADDR);
                    end
                    PH_AB_V0RD: begin
                        if (rd != PAT_A) r = fail_at(0, ST_ADDR);
                        else begin
                            probe = 4; phase = PH_AB_VRD;
                            r = cmd(K_READ, 4, 0, ST_ADDR);
                        end
                    end
                    PH_AB_VRD: begin
                        if (rd != PAT_A && probe != victim) r = fail_at(probe, ST_ADDR);
                        else begin
                            probe = probe << 1;
                            if (probe < size) r = cmd(K_READ, probe, 0, ST_ADDR);
                            else begin
                                phase = PH_AB_VRST;
                                r = cmd(K_WRITE, victim, PAT_A, ST_ADDR);
                            end
                        end
                    end
                    PH_AB_VRST: begin
                        victim = victim << 1;
                        if (victim < size) begin
                            phase = PH_AB_VW;
                            r = cmd(K_WRITE, victim, PAT_B, ST_ADDR);
                        end else r = start_sweep();
                    end
                    PH_SW_WR: begin
                        probe = probe + 4;
                        if (probe < size) begin
                            sweep_val = hash32(sweep_val);
                            r = cmd(K_WRITE, probe, sweep_val, ST_SWEEP);
                        end else begin
                            exp_word = hash32(sweep_seed);
                            probe = 0; phase = PH_SW_RD;
                            r = cmd(K_READ, 0, 0, ST_SWEEP);
                        end
                    end
                    PH_SW_RD: begin
                        if (rd != exp_word) r = fail_at(probe, ST_SWEEP);
                        else begin
                            probe = probe + 4;
                            if (probe < size) begin
                                exp_word = hash32(exp_word);
                                r = cmd(K_READ, probe, 0, ST_SWEEP);
                            end else begin
                                phase = PH_IDLE;
                                r = cmd(K_PASS, 0, 0, ST_SWEEP);
                            end
                        end
                    end
                    default: r = fail_at(0, ST_DATA);
                endcase
            end
            if (r.command_kind == K_WRITE) mem_image[64'(r.byte_offset)] = r.write_value;
            last_cmd = r;
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (pending.size() == 0) begin
                report("unexpected word", got[63:0], 64'd0);
                return;
            end
            want = pending.pop_front();
            if (got.command_kind != want.command_kind)
                report("command_kind", 64'(got.command_kind), 64'(want.command_kind));
            if (got.byte_offset != want.byte_offset)
                report("byte_offset", 64'(got.byte_offset), 64'(want.byte_offset));
            if (got.write_value != want.write_value)
                report("write_value", 64'(got.write_value), 64'(want.write_value));
            if (got.test_stage != want.test_stage)
                report("test_stage", 64'(got.test_stage), 64'(want.test_stage));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    selftest_scoreboard sb = new();
    bit fast_mode = 1'b0;
    bit hold_req = 1'b0;
    int idle_cycles = 0;

    memory_bus_test_sequencer_top i_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = fast_mode ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_out_data);
        end
    end

    task write_reg(logic [0:0] index, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {index, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (index == REG_SIZE) sb.size_log2 = value[4:0];
        else sb.sweep_seed = value;
    endtask

    task send_word(logic op, logic [31:0] rd);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data <= '{operation: op, read_data: rd};
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(i_in_data);
        gap = fast_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task send_answer();
        logic [31:0] rd;
        logic [63:0] off;
        off = 64'(sb.last_cmd.byte_offset);
        if (sb.last_cmd.command_kind == K_READ && sb.mem_image.exists(off))
            rd = sb.mem_image[off];
        else
            rd = $urandom;
        if ($urandom_range(0, 99) < 2) rd = rd ^ (32'd1 << $urandom_range(0, 31));
        else if ($urandom_range(0, 199) == 0) rd = $urandom;
        send_word($urandom_range(0, 79) != 0, rd);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        logic [4:0]  sizes[8] = '{5'd3, 5'd4, 5'd5, 5'd31, 5'd6, 5'd30, 5'd8, 5'd3};
        logic [31:0] seeds[8];
        int counts[8] = '{240, 240, 260, 160, 300, 160, 300, 190};
        seeds = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'h8000_0001, $urandom, 32'd1,
                  $urandom, 32'h0000_FFFF};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(1'b1, 32'd0);
        send_word(1'b1, 32'hFFFF_FFFF);
        send_word(1'b1, 32'd1);
        send_word(1'b1, 32'd0);
        send_word(1'b0, 32'hFFFF_FFFF);
        send_word(1'b1, 32'd0);
        send_word(1'b1, 32'h8000_0000);
        send_word(1'b1, 32'hFFFF_FFFF);
        send_word(1'b1, 32'd0);
        send_word(1'b1, 32'd1);
        send_word(1'b1, 32'd1);
        send_word(1'b0, 32'h5555_5555);
        send_word(1'b0, 32'hAAAA_AAAA);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_SIZE, {27'd0, sizes[p]});
            write_reg(REG_SEED, seeds[p]);
            fast_mode = (p == 4);
            send_word(1'b0, $urandom);
            for (int n = 0; n < counts[p]; n++) begin
                if (p == 2 && n == 40) hold_req = 1'b1;
                if (p == 6 && n == 100) wait_drained();
                send_answer();
            end
            wait_drained();
        end

        fast_mode = 1'b0;
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
